@@ sv/grcb_pkg.sv @@
// Constants and codes for the gamma ramp compose/blend block.
// No dependencies; used by gamma_ramp_compose_blend_top.
package grcb_pkg;

  localparam int RAMP_ENTRIES  = 256;
  localparam int CHANNEL_COUNT = 3;
  localparam int TABLE_DEPTH   = CHANNEL_COUNT * RAMP_ENTRIES;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);

  // Blend fraction thresholds (Q1.16)
  localparam logic [16:0] T_HIGH      = 17'd65471;
  localparam logic [16:0] T_LOW       = 17'd65;
  localparam logic [16:0] T_RESET     = 17'd65536;

  // floor(v/257) for 16-bit v is (v * 65281) >> 24
  localparam logic [16:0] RECIP_257_S = 17'd65281;
  // floor(x/257) for x below 2^24 is (x * 0xFF0100) >> 32
  localparam logic [23:0] RECIP_257_L = 24'hFF0100;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_COMPOSE = 2'd1,
    MODE_BLEND   = 2'd2
  } mode_e;

endpackage

@@ sv/gamma_ramp_compose_blend_top.sv @@
// Gamma ramp compose/blend block: baseline table, shared multiplier, rounding.
// Depends on grcb_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries mode, channel, index, value.
//   Load transfers write one baseline word and produce no result; compose and
//   blend transfers on channels 0 to 2 give one result on the output channel
//   (out_valid_o/out_ready_i), in order.
//   cfg_we_i writes the blend fraction (17 bits); write it only while idle.
//   Throughput: one item per cycle when not stalled, set by the single-pass
//   pipeline of table read, multiply, divide-by-reciprocal and add/clamp stages.
//   The table has one write port and two registered read ports; a load is
//   seen by any item transferred on a later cycle.
//   Reset clears the pipeline valids and sets the fraction to full target.
//   The baseline table is not cleared and holds nothing useful until loaded.
//   When the receiver stalls, the result holds; up to three more compose or
//   blend items are taken into the empty stages behind it, then in_ready_o drops.
module gamma_ramp_compose_blend_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [1:0]  channel_i,
  input  logic [7:0]  index_i,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_channel_o,
  output logic [7:0]  result_index_o,
  output logic [15:0] result_value_o
);

  logic [15:0] base_mem_q [grcb_pkg::TABLE_DEPTH];
  logic [16:0] frac_q;

  // stage enables
  logic en1, en2, en3, en_out;
  logic s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;

  // input decode
  logic                        in_xfer, chan_ok, produces;
  logic [32:0]                 lo_prod;
  logic [7:0]                  in_lo, in_hi;
  logic [grcb_pkg::ADDR_W-1:0] wr_addr, rd_lo_addr, rd_hi_addr;

  // stage 1
  logic        s1_comp_q;
  logic [1:0]  s1_chan_q;
  logic [7:0]  s1_idx_q, s1_lo_q;
  logic [15:0] s1_val_q, s1_blo_q, s1_bhi_q;

  // stage 2
  logic [16:0]        r_full;
  logic signed [16:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [34:0] prod;
  logic               take_val, take_base;
  logic [33:0]        s2_prod_q;
  logic               s2_comp_q, s2_take_val_q, s2_take_base_q;
  logic [1:0]         s2_chan_q;
  logic [7:0]         s2_idx_q;
  logic [15:0]        s2_val_q, s2_base_q;

  // stage 3
  logic        neg;
  logic [33:0] prod_neg;
  logic [32:0] mag;
  logic [23:0] cx;
  logic [47:0] cprod;
  logic [33:0] bx;
  logic [15:0] quot;
  logic [15:0] s3_q_q, s3_val_q, s3_base_q;
  logic        s3_neg_q, s3_take_val_q, s3_take_base_q;
  logic [1:0]  s3_chan_q;
  logic [7:0]  s3_idx_q;

  // stage 4
  logic signed [17:0] sum;
  logic [15:0]        res;
  logic [1:0]         res_chan_q;
  logic [7:0]         res_idx_q;
  logic [15:0]        res_val_q;

  assign en_out     = !out_vld_q || out_ready_i;
  assign en3        = !s3_vld_q || en_out;
  assign en2        = !s2_vld_q || en3;
  assign en1        = !s1_vld_q || en2;
  assign in_ready_o = en1;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign chan_ok  = channel_i < 2'(grcb_pkg::CHANNEL_COUNT);
  assign produces = in_xfer && chan_ok &&
                    (mode_i == grcb_pkg::MODE_COMPOSE || mode_i == grcb_pkg::MODE_BLEND);

  assign lo_prod    = value_i * grcb_pkg::RECIP_257_S;
  assign in_lo      = lo_prod[31:24];
  assign in_hi      = (in_lo == 8'hFF) ? in_lo : in_lo + 8'd1;
  assign wr_addr    = {channel_i, index_i};
  assign rd_lo_addr = (mode_i == grcb_pkg::MODE_COMPOSE) ? {channel_i, in_lo}
                                                          : {channel_i, index_i};
  assign rd_hi_addr = {channel_i, in_hi};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q    <= grcb_pkg::T_RESET;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) frac_q <= cfg_wdata_i;
      if (en1)      s1_vld_q  <= produces;
      if (en2)      s2_vld_q  <= s1_vld_q;
      if (en3)      s3_vld_q  <= s2_vld_q;
      if (en_out)   out_vld_q <= s3_vld_q;
    end
  end

  // table: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (in_xfer && chan_ok && mode_i == grcb_pkg::MODE_LOAD) begin
      base_mem_q[wr_addr] <= value_i;
    end
    if (produces) begin
      s1_blo_q  <= base_mem_q[rd_lo_addr];
      s1_bhi_q  <= base_mem_q[rd_hi_addr];
      s1_comp_q <= (mode_i == grcb_pkg::MODE_COMPOSE);
      s1_chan_q <= channel_i;
      s1_idx_q  <= index_i;
      s1_val_q  <= value_i;
      s1_lo_q   <= in_lo;
    end
  end

  // stage 2: remainder, difference, shared multiplier
  always_comb begin
    r_full    = {1'b0, s1_val_q} - {1'b0, s1_lo_q, 8'd0} - {9'd0, s1_lo_q};
    take_val  = 1'b0;
    take_base = 1'b0;
    if (s1_comp_q) begin
      mul_a = $signed({1'b0, s1_bhi_q}) - $signed({1'b0, s1_blo_q});
      mul_b = $signed({9'd0, r_full[8:0]});
    end else begin
      mul_a     = $signed({1'b0, s1_val_q}) - $signed({1'b0, s1_blo_q});
      mul_b     = $signed({1'b0, frac_q});
      take_val  = frac_q >= grcb_pkg::T_HIGH;
      take_base = frac_q <= grcb_pkg::T_LOW;
    end
    prod = mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s1_vld_q) begin
      s2_prod_q      <= prod[33:0];
      s2_comp_q      <= s1_comp_q;
      s2_take_val_q  <= take_val;
      s2_take_base_q <= take_base;
      s2_chan_q      <= s1_chan_q;
      s2_idx_q       <= s1_idx_q;
      s2_val_q       <= s1_val_q;
      s2_base_q      <= s1_blo_q;
    end
  end

  // stage 3: rounded magnitude, halves away from zero
  always_comb begin
    neg      = s2_prod_q[33];
    prod_neg = 34'd0 - s2_prod_q;
    mag      = neg ? prod_neg[32:0] : s2_prod_q[32:0];
    cx       = mag[23:0] + 24'd128;
    cprod    = cx * grcb_pkg::RECIP_257_L;
    bx       = {1'b0, mag} + 34'd32768;
    quot     = s2_comp_q ? cprod[47:32] : bx[31:16];
  end

  always_ff @(posedge clk_i) begin
    if (en3 && s2_vld_q) begin
      s3_q_q         <= quot;
      s3_neg_q       <= neg;
      s3_take_val_q  <= s2_take_val_q;
      s3_take_base_q <= s2_take_base_q;
      s3_chan_q      <= s2_chan_q;
      s3_idx_q       <= s2_idx_q;
      s3_val_q       <= s2_val_q;
      s3_base_q      <= s2_base_q;
    end
  end

  // stage 4: offset from base, clamp, threshold cases
  always_comb begin
    if (s3_neg_q) sum = $signed({2'b00, s3_base_q}) - $signed({2'b00, s3_q_q});
    else          sum = $signed({2'b00, s3_base_q}) + $signed({2'b00, s3_q_q});
    priority if (s3_take_val_q)   res = s3_val_q;
    else if (s3_take_base_q)      res = s3_base_q;
    else if (sum < 18'sd0)        res = 16'd0;
    else if (sum > 18'sd65535)    res = 16'hFFFF;
    else                          res = sum[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_out && s3_vld_q) begin
      res_chan_q <= s3_chan_q;
      res_idx_q  <= s3_idx_q;
      res_val_q  <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign result_channel_o = res_chan_q;
  assign result_index_o   = res_idx_q;
  assign result_value_o   = res_val_q;

  a_full_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i && s1_vld_q && s2_vld_q && s3_vld_q |-> !in_ready_o)
    else $error("input taken while pipeline full and stalled");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i == grcb_pkg::MODE_LOAD |=> !s1_vld_q)
    else $error("load transfer entered the result pipeline");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> $onehot0({s2_take_val_q, s2_take_base_q}))
    else $error("blend threshold cases overlap");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !s3_vld_q |=> !out_valid_o)
    else $error("result repeated after transfer");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for gamma_ramp_compose_blend_top: directed table then random traffic.
// A ramp predictor mirrors the baseline table and blend fraction; results are checked in order.
// Depends on grcb_pkg and the block RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] CH_RED     = 2'd0;
  localparam logic [1:0] CH_GREEN   = 2'd1;
  localparam logic [1:0] CH_BLUE    = 2'd2;
  localparam logic [1:0] CH_BAD     = 2'd3;

  localparam int DIR_ROWS       = 30;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 140;
  localparam int DRAIN_PAD      = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  mode;
    logic [1:0]  chan;
    logic [7:0]  idx;
    logic [16:0] val;
    logic        typed;
    logic [15:0] tval;
  } stim_row_t;

  typedef struct {
    logic        typed;
    logic [15:0] tval;
  } item_tag_t;

  typedef struct {
    logic [1:0]  chan;
    logic [7:0]  idx;
    logic [15:0] value;
  } ramp_word_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic [1:0]  mode      = '0;
  logic [1:0]  chan      = '0;
  logic [7:0]  idx       = '0;
  logic [15:0] value     = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  res_chan;
  logic [7:0]  res_idx;
  logic [15:0] res_value;

  gamma_ramp_compose_blend_top i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .mode_i           (mode),
    .channel_i        (chan),
    .index_i          (idx),
    .value_i          (value),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .result_channel_o (res_chan),
    .result_index_o   (res_idx),
    .result_value_o   (res_value)
  );

  // Predictor state
  logic [15:0] ramp_base [grcb_pkg::CHANNEL_COUNT][grcb_pkg::RAMP_ENTRIES];
  logic [16:0] frac_model = grcb_pkg::T_RESET;
  bit          gen_loaded [grcb_pkg::CHANNEL_COUNT][grcb_pkg::RAMP_ENTRIES];
  item_tag_t   tag_q[$];
  ramp_word_t  ramp_q[$];

  int unsigned fail_cnt     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left   = 0;
  int unsigned gap_max      = 3;
  bit          rand_go      = 1'b0;

  stim_row_t dir_tbl [DIR_ROWS] = '{
    '{ROW_ITEM, grcb_pkg::MODE_LOAD,    CH_RED,   8'd0,   17'd0,     1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_LOAD,    CH_RED,   8'd1,   17'd65535, 1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_LOAD,    CH_RED,   8'd254, 17'd0,     1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_LOAD,    CH_RED,   8'd255, 17'd65535, 1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_COMPOSE, CH_RED,   8'd7,   17'd0,     1'b1, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_COMPOSE, CH_RED,   8'd255, 17'd256,   1'b1, 16'd65280},
    '{ROW_ITEM, grcb_pkg::MODE_COMPOSE, CH_RED,   8'd0,   17'd65535, 1'b1, 16'd65535},
    '{ROW_ITEM, grcb_pkg::MODE_COMPOSE, CH_RED,   8'd128, 17'd65534, 1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_BLEND,   CH_RED,   8'd1,   17'd123,   1'b1, 16'd123},
    '{ROW_ITEM, MODE_SPARE,             CH_RED,   8'd0,   17'd5,     1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_LOAD,    CH_BAD,   8'd0,   17'd77,    1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_COMPOSE, CH_BAD,   8'd0,   17'd0,     1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_BLEND,   CH_BAD,   8'd255, 17'd65535, 1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_LOAD,    CH_BLUE,  8'd255, 17'd4660,  1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_LOAD,    CH_GREEN, 8'd0,   17'd1000,  1'b0, 16'd0},
    '{ROW_CFG,  grcb_pkg::MODE_LOAD,    CH_RED,   8'd0,   grcb_pkg::T_LOW, 1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_BLEND,   CH_RED,   8'd1,   17'd0,     1'b1, 16'd65535},
    '{ROW_CFG,  grcb_pkg::MODE_LOAD,    CH_RED,   8'd0,   17'd66,    1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_BLEND,   CH_RED,   8'd1,   17'd0,     1'b0, 16'd0},
    '{ROW_CFG,  grcb_pkg::MODE_LOAD,    CH_RED,   8'd0,   17'd32768, 1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_BLEND,   CH_RED,   8'd0,   17'd65535, 1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_BLEND,   CH_RED,   8'd1,   17'd0,     1'b0, 16'd0},
    '{ROW_CFG,  grcb_pkg::MODE_LOAD,    CH_RED,   8'd0,   17'd65470, 1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_BLEND,   CH_BLUE,  8'd255, 17'd0,     1'b0, 16'd0},
    '{ROW_CFG,  grcb_pkg::MODE_LOAD,    CH_RED,   8'd0,   grcb_pkg::T_HIGH, 1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_BLEND,   CH_BLUE,  8'd255, 17'd0,     1'b1, 16'd0},
    '{ROW_CFG,  grcb_pkg::MODE_LOAD,    CH_RED,   8'd0,   17'h1FFFF, 1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_BLEND,   CH_GREEN, 8'd0,   17'd65535, 1'b1, 16'd65535},
    '{ROW_CFG,  grcb_pkg::MODE_LOAD,    CH_RED,   8'd0,   17'd0,     1'b0, 16'd0},
    '{ROW_ITEM, grcb_pkg::MODE_BLEND,   CH_GREEN, 8'd0,   17'd65535, 1'b1, 16'd1000}
  };

  logic [16:0] phase_frac [8] = '{
    grcb_pkg::T_RESET, 17'd0, grcb_pkg::T_LOW, grcb_pkg::T_LOW + 17'd1, 17'd32768,
    grcb_pkg::T_HIGH - 17'd1, grcb_pkg::T_HIGH, 17'h1FFFF
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round to nearest, halves away from zero
  function automatic longint div_nearest(longint num, longint den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((2 * (-num) + den) / (2 * den));
  endfunction

  function automatic logic [15:0] clamp_word(longint q);
    if (q < 0) return 16'd0;
    if (q > 65535) return 16'hFFFF;
    return 16'(q);
  endfunction

  function automatic logic [15:0] compose_word(logic [1:0] c, logic [15:0] v);
    longint lo, r, hi, blo, bhi;
    lo  = longint'(v) / 257;
    r   = longint'(v) % 257;
    hi  = (lo < grcb_pkg::RAMP_ENTRIES - 1) ? lo + 1 : grcb_pkg::RAMP_ENTRIES - 1;
    blo = longint'(ramp_base[c][lo]);
    bhi = longint'(ramp_base[c][hi]);
    return clamp_word(blo + div_nearest((bhi - blo) * r, 257));
  endfunction

  function automatic logic [15:0] blend_word(logic [1:0] c, logic [7:0] x, logic [15:0] v);
    longint b;
    b = longint'(ramp_base[c][x]);
    if (frac_model >= grcb_pkg::T_HIGH) return v;
    if (frac_model <= grcb_pkg::T_LOW) return 16'(b);
    return clamp_word(b + div_nearest((longint'(v) - b) * longint'(frac_model), 65536));
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Scoreboard: predict on input transfer, check on output transfer
  item_tag_t  acc_tag;
  ramp_word_t got_word;

  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      acc_tag = tag_q.pop_front();
      if (chan < grcb_pkg::CHANNEL_COUNT) begin
        case (mode)
          grcb_pkg::MODE_LOAD: ramp_base[chan][idx] = value;
          grcb_pkg::MODE_COMPOSE, grcb_pkg::MODE_BLEND: begin
            got_word.chan  = chan;
            got_word.idx   = idx;
            got_word.value = (mode == grcb_pkg::MODE_COMPOSE) ? compose_word(chan, value)
                                                              : blend_word(chan, idx, value);
            if (acc_tag.typed) got_word.value = acc_tag.tval;
            ramp_q.push_back(got_word);
          end
          default: ;
        endcase
      end
    end
    if (out_valid && out_ready) begin
      if (ramp_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("unexpected result: chan %0d idx %0d value %0d",
                   res_chan, res_idx, res_value);
      end else begin
        got_word = ramp_q.pop_front();
        if (res_chan !== got_word.chan || res_idx !== got_word.idx ||
            res_value !== got_word.value) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("mismatch: exp chan %0d idx %0d value %0d, got chan %0d idx %0d value %0d",
                     got_word.chan, got_word.idx, got_word.value,
                     res_chan, res_idx, res_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** gamma_ramp_compose_blend_top: FAILED **");
      $finish;
    end
  end

  // Receiver: changing stall pattern, one long hold-off once random traffic starts
  initial begin : receiver
    int unsigned pat;
    int unsigned left;
    int unsigned hold;
    int unsigned cyc;
    bit          held;
    pat  = 0;
    left = 0;
    hold = 0;
    cyc  = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rand_go && !held) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (left == 0) begin
        pat  = $urandom_range(0, 3);
        left = $urandom_range(50, 200);
      end
      left--;
      if (hold != 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (pat)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (cyc % 4 != 3);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic drive_item(input logic [1:0] m, input logic [1:0] c, input logic [7:0] x,
                            input logic [15:0] v, input logic typed, input logic [15:0] tv);
    int unsigned gap;
    item_tag_t   tag;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    tag.typed = typed;
    tag.tval  = tv;
    tag_q.push_back(tag);
    if (m == grcb_pkg::MODE_LOAD && c < grcb_pkg::CHANNEL_COUNT) gen_loaded[c][x] = 1'b1;
    in_valid <= 1'b1;
    mode     <= m;
    chan     <= c;
    idx      <= x;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (ramp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_fraction(input logic [16:0] t);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we     <= 1'b0;
    frac_model = t;
  endtask

  // Reads of unloaded entries are turned into loads of those entries
  task automatic random_item(output bit counted);
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    logic [1:0]  m;
    logic [1:0]  c;
    logic [7:0]  x;
    logic [15:0] v;
    pick    = $urandom_range(0, 99);
    m       = 2'($urandom);
    c       = 2'($urandom_range(0, grcb_pkg::CHANNEL_COUNT - 1));
    x       = 8'($urandom);
    v       = rand_word();
    counted = 1'b1;
    if (pick < 4) begin
      m       = MODE_SPARE;
      c       = 2'($urandom);
      counted = 1'b0;
    end else if (pick < 8) begin
      c       = CH_BAD;
      counted = 1'b0;
    end else if (pick < 38) begin
      m = grcb_pkg::MODE_LOAD;
    end else if (pick < 69) begin
      m = grcb_pkg::MODE_COMPOSE;
      if ($urandom_range(0, 7) == 0) v = 16'($urandom_range(0, 255) * 257);
      lo = v / 257;
      hi = (lo < grcb_pkg::RAMP_ENTRIES - 1) ? lo + 1 : lo;
      if (!gen_loaded[c][lo]) begin
        m = grcb_pkg::MODE_LOAD;
        x = 8'(lo);
        v = rand_word();
      end else if (!gen_loaded[c][hi]) begin
        m = grcb_pkg::MODE_LOAD;
        x = 8'(hi);
        v = rand_word();
      end
    end else begin
      m = grcb_pkg::MODE_BLEND;
      if (!gen_loaded[c][x]) m = grcb_pkg::MODE_LOAD;
    end
    drive_item(m, c, x, v, 1'b0, 16'd0);
  endtask

  initial begin : stimulus
    int unsigned n;
    bit          counted;
    logic [16:0] t;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG)
        write_fraction(dir_tbl[i].val);
      else
        drive_item(dir_tbl[i].mode, dir_tbl[i].chan, dir_tbl[i].idx,
                   dir_tbl[i].val[15:0], dir_tbl[i].typed, dir_tbl[i].tval);
    end
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 8) t = phase_frac[ph];
      else if (ph == 8) t = 17'($urandom_range(grcb_pkg::T_LOW + 1, grcb_pkg::T_HIGH - 1));
      else t = 17'($urandom_range(0, 17'h1FFFF));
      write_fraction(t);
      gap_max = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 4 : 12);
      if (ph == 0) rand_go = 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        random_item(counted);
        if (counted) n++;
      end
    end
    drain();
    if (fail_cnt == 0 && ramp_q.size() == 0)
      $display("** gamma_ramp_compose_blend_top: PASSED **");
    else
      $display("** gamma_ramp_compose_blend_top: FAILED **");
    $finish;
  end

endmodule
